// ===== design/tga_image_stream_decoder_macros.svh =====
// Assertion macros for the TGA image stream decoder.
// Used by design/tga_image_stream_decoder.sv; no other dependencies.
`ifndef TGA_IMAGE_STREAM_DECODER_MACROS_SVH
`define TGA_IMAGE_STREAM_DECODER_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted (active low).
`define TGA_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("tga decoder check failed");
// Clocked check that also runs during reset.
`define TGA_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("tga decoder check failed");
`else
`define TGA_ASSERT(label, clk, rstn, prop)
`define TGA_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== design/tga_pkg.sv =====
// Package for the TGA image stream decoder: transaction structs, result and
// error codes, header constants. No dependencies.
package tga_pkg;

    // Result kinds
    localparam logic [1:0] RK_SPAN  = 2'd0;
    localparam logic [1:0] RK_INFO  = 2'd1;
    localparam logic [1:0] RK_ERROR = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_TYPE   = 2'd1;
    localparam logic [1:0] ERR_INFO   = 2'd2;
    localparam logic [1:0] ERR_PIXELS = 2'd3;

    // Header layout
    localparam int unsigned TYPE_HDR_BYTES = 12;
    localparam int unsigned INFO_HDR_BYTES = 6;
    localparam logic [3:0]  TYPE_BYTE_POS  = 4'd2;
    localparam logic [7:0]  TYPE_RAW       = 8'd2;
    localparam logic [7:0]  TYPE_RLE       = 8'd10;
    localparam logic [7:0]  BPP_RGB        = 8'd24;
    localparam logic [7:0]  BPP_RGBA       = 8'd32;

    // Uncompressed type header; the type byte is checked separately
    localparam logic [7:0] TYPE_HDR_RAW [TYPE_HDR_BYTES] = '{
        8'd0, 8'd0, 8'd2, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } tga_in_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  span_length;
        logic        last_of_image;
        logic [1:0]  error_code;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        has_alpha;
    } tga_out_t;

endpackage

// ===== design/tga_image_stream_decoder.sv =====
// TGA image stream decoder, top level: header parsing, packet/pixel decode
// and a two-entry result buffer. Depends on tga_pkg and the macros header.
//
// Takes one TGA file byte per cycle while s_ready is high, fully pipelined:
// every byte is decoded in the cycle it is accepted and any result (image
// info, pixel span or error) is registered into the result register that
// drives m_, or into the skid register while a result waits on m_ready, so
// the input keeps taking one byte per cycle; s_ready drops only when both
// result registers are full. Bytes with restart set begin a new file; after
// the last pixel or an error the decoder swallows bytes silently until the
// next restart. Run packets give a single span result with the repeat count.
`include "tga_image_stream_decoder_macros.svh"

module tga_image_stream_decoder (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tga_pkg::tga_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output tga_pkg::tga_out_t m_data
);
    import tga_pkg::*;

    // Parse phases
    localparam logic [2:0] PH_TYPE = 3'd0;
    localparam logic [2:0] PH_INFO = 3'd1;
    localparam logic [2:0] PH_PKT  = 3'd2;
    localparam logic [2:0] PH_PIX  = 3'd3;
    localparam logic [2:0] PH_DONE = 3'd4;

    // Parser state
    logic [2:0]  phase_reg,       phase_next;
    logic [3:0]  hdr_count_reg,   hdr_count_next;
    logic        compressed_reg,  compressed_next;
    logic        mismatch_reg,    mismatch_next;
    logic        info_bad_reg,    info_bad_next;
    logic [15:0] width_reg,       width_next;
    logic [15:0] height_reg,      height_next;
    logic        alpha_on_reg,    alpha_on_next;
    logic [31:0] pixels_left_reg, pixels_left_next;
    logic [7:0]  packet_left_reg, packet_left_next;
    logic        packet_run_reg,  packet_run_next;
    logic [1:0]  byte_idx_reg,    byte_idx_next;
    logic [7:0]  pix_byte_reg [3];

    // Result buffer
    logic        out_valid_reg;
    tga_out_t    out_data_reg;
    logic        skid_valid_reg;
    tga_out_t    skid_data_reg;

    // Decode outputs
    logic        accept;
    logic        has_result;
    tga_out_t    result;
    logic        pix_we;
    logic [7:0]  din;
    logic [2:0]  cur_phase;
    logic [3:0]  cur_count;
    logic [7:0]  pkt_count;
    logic [7:0]  span;

    assign accept  = s_valid && s_ready;
    assign s_ready = !skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;
    assign din     = s_data.data_byte;
    // Run and raw packets both carry count minus one in the low seven bits
    assign pkt_count = {1'b0, din[6:0]} + 8'd1;

    // Byte decode; restart makes this byte the first of a fresh file
    always_comb begin
        cur_phase        = s_data.restart ? PH_TYPE : phase_reg;
        cur_count        = s_data.restart ? 4'd0 : hdr_count_reg;
        compressed_next  = s_data.restart ? 1'b0 : compressed_reg;
        mismatch_next    = s_data.restart ? 1'b0 : mismatch_reg;
        info_bad_next    = s_data.restart ? 1'b0 : info_bad_reg;
        width_next       = s_data.restart ? 16'd0 : width_reg;
        height_next      = s_data.restart ? 16'd0 : height_reg;
        alpha_on_next    = s_data.restart ? 1'b0 : alpha_on_reg;
        pixels_left_next = s_data.restart ? 32'd0 : pixels_left_reg;
        packet_left_next = s_data.restart ? 8'd0 : packet_left_reg;
        packet_run_next  = s_data.restart ? 1'b0 : packet_run_reg;
        byte_idx_next    = s_data.restart ? 2'd0 : byte_idx_reg;
        phase_next       = cur_phase;
        hdr_count_next   = cur_count;
        has_result       = 1'b0;
        pix_we           = 1'b0;
        span             = 8'd0;
        result           = '0;

        case (cur_phase)
            PH_TYPE: begin
                if (cur_count == TYPE_BYTE_POS) begin
                    if (din == TYPE_RLE) begin
                        compressed_next = 1'b1;
                    end else if (din != TYPE_RAW) begin
                        mismatch_next = 1'b1;
                    end
                end else if (din != TYPE_HDR_RAW[cur_count]) begin
                    mismatch_next = 1'b1;
                end
                if (cur_count == 4'(TYPE_HDR_BYTES - 1)) begin
                    hdr_count_next = 4'd0;
                    if (mismatch_next) begin
                        has_result         = 1'b1;
                        result.result_kind = RK_ERROR;
                        result.error_code  = ERR_TYPE;
                        phase_next         = PH_DONE;
                    end else begin
                        phase_next = PH_INFO;
                    end
                end else begin
                    hdr_count_next = cur_count + 4'd1;
                end
            end
            PH_INFO: begin
                case (cur_count)
                    4'd0: width_next  = {width_next[15:8], din};
                    4'd1: width_next  = {din, width_next[7:0]};
                    4'd2: height_next = {height_next[15:8], din};
                    4'd3: height_next = {din, height_next[7:0]};
                    4'd4: begin
                        alpha_on_next = (din == BPP_RGBA);
                        info_bad_next = (din != BPP_RGB) && (din != BPP_RGBA);
                    end
                    default: ;
                endcase
                if (cur_count < 4'(INFO_HDR_BYTES - 1)) begin
                    hdr_count_next = cur_count + 4'd1;
                end else begin
                    hdr_count_next = 4'd0;
                    has_result     = 1'b1;
                    if (info_bad_next || width_next == 16'd0 || height_next == 16'd0) begin
                        result.result_kind = RK_ERROR;
                        result.error_code  = ERR_INFO;
                        phase_next         = PH_DONE;
                    end else begin
                        pixels_left_next    = 32'(width_next) * 32'(height_next);
                        byte_idx_next       = 2'd0;
                        packet_run_next     = 1'b0;
                        packet_left_next    = 8'd0;
                        phase_next          = compressed_next ? PH_PKT : PH_PIX;
                        result.result_kind  = RK_INFO;
                        result.image_width  = width_next;
                        result.image_height = height_next;
                        result.has_alpha    = alpha_on_next;
                    end
                end
            end
            PH_PKT: begin
                if ({24'd0, pkt_count} > pixels_left_next) begin
                    has_result         = 1'b1;
                    result.result_kind = RK_ERROR;
                    result.error_code  = ERR_PIXELS;
                    phase_next         = PH_DONE;
                end else begin
                    packet_run_next  = din[7];
                    packet_left_next = pkt_count;
                    byte_idx_next    = 2'd0;
                    phase_next       = PH_PIX;
                end
            end
            PH_PIX: begin
                pix_we = (byte_idx_next != 2'd3);
                if (alpha_on_next ? (byte_idx_next != 2'd3) : (byte_idx_next != 2'd2)) begin
                    byte_idx_next = byte_idx_next + 2'd1;
                end else begin
                    byte_idx_next = 2'd0;
                    if (!compressed_next) begin
                        span = 8'd1;
                    end else if (packet_run_next) begin
                        span             = packet_left_next;
                        packet_left_next = 8'd0;
                    end else begin
                        span             = 8'd1;
                        packet_left_next = packet_left_next - 8'd1;
                    end
                    // Clamp to the pixels still owed
                    if ({24'd0, span} > pixels_left_next) begin
                        span = pixels_left_next[7:0];
                    end
                    pixels_left_next = pixels_left_next - {24'd0, span};
                    if (pixels_left_next == 32'd0) begin
                        phase_next = PH_DONE;
                    end else if (compressed_next && packet_left_next == 8'd0) begin
                        phase_next = PH_PKT;
                    end
                    has_result           = 1'b1;
                    result.result_kind   = RK_SPAN;
                    result.red           = (byte_idx_reg == 2'd2 || s_data.restart) ?
                                           din : pix_byte_reg[2];
                    result.green         = pix_byte_reg[1];
                    result.blue          = pix_byte_reg[0];
                    result.alpha         = alpha_on_next ? din : 8'd0;
                    result.span_length   = span;
                    result.last_of_image = (pixels_left_next == 32'd0);
                end
            end
            default: begin
                phase_next = PH_DONE;
            end
        endcase
    end

    // Parser state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_TYPE;
            hdr_count_reg   <= 4'd0;
            compressed_reg  <= 1'b0;
            mismatch_reg    <= 1'b0;
            info_bad_reg    <= 1'b0;
            width_reg       <= 16'd0;
            height_reg      <= 16'd0;
            alpha_on_reg    <= 1'b0;
            pixels_left_reg <= 32'd0;
            packet_left_reg <= 8'd0;
            packet_run_reg  <= 1'b0;
            byte_idx_reg    <= 2'd0;
        end else if (accept) begin
            phase_reg       <= phase_next;
            hdr_count_reg   <= hdr_count_next;
            compressed_reg  <= compressed_next;
            mismatch_reg    <= mismatch_next;
            info_bad_reg    <= info_bad_next;
            width_reg       <= width_next;
            height_reg      <= height_next;
            alpha_on_reg    <= alpha_on_next;
            pixels_left_reg <= pixels_left_next;
            packet_left_reg <= packet_left_next;
            packet_run_reg  <= packet_run_next;
            byte_idx_reg    <= byte_idx_next;
        end
    end

    // Stored pixel bytes, written at the current byte position
    always_ff @(posedge aclk) begin
        if (accept && pix_we) begin
            if (s_data.restart) begin
                pix_byte_reg[0] <= din;
            end else begin
                pix_byte_reg[byte_idx_reg] <= din;
            end
        end
    end

    // Result register plus skid register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= accept && has_result;
            end
        end else if (accept && has_result) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : result;
        end
        if (out_valid_reg && !m_ready && !skid_valid_reg) begin
            skid_data_reg <= result;
        end
    end

    // Checks
    `TGA_ASSERT(a_skid_needs_out, aclk, aresetn, skid_valid_reg |-> out_valid_reg)
    `TGA_ASSERT(a_pixels_owed, aclk, aresetn, (phase_reg == PH_PKT || phase_reg == PH_PIX) |-> pixels_left_reg != 32'd0)
    `TGA_ASSERT(a_span_range, aclk, aresetn, (m_valid && m_data.result_kind == RK_SPAN) |-> (m_data.span_length != 8'd0 && m_data.span_length <= 8'd128))
    `TGA_ASSERT(a_done_silent, aclk, aresetn, (accept && !s_data.restart && phase_reg == PH_DONE) |=> !skid_valid_reg || $past(skid_valid_reg))

endmodule
